>>> design/aes_pkg.sv
// ============================================================================
// AES package
// Shared constants, types and byte-level functions for the AES block cipher.
// ============================================================================
package aes_pkg;

    localparam int RoundKeyWordsDefault = 60;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] CFG_KEY_MODE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_A    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_KEY_B    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_KEY_C    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_KEY_D    = 3'd4;

    localparam logic REQ_ENCRYPT = 1'b0;
    localparam logic REQ_DECRYPT = 1'b1;

    typedef struct packed {
        logic [63:0] block_hi;
        logic [63:0] block_lo;
        logic        req_type;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] out_hi;
        logic [63:0] out_lo;
    } out_beat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] p);
        return {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix as a pre-step (multiply by 04/05 pattern) then forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

>>> design/aes_stream_if.sv
// ============================================================================
// AES stream interface
// Valid/ready channel carrying one payload beat.
// ============================================================================
interface aes_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/aes_ram.sv
// ============================================================================
// AES generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> design/aes_round.sv
// ============================================================================
// AES round unit
// One encrypt/decrypt round (key add only, full, or final), combinational.
// ============================================================================
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    input  logic         decrypt,
    input  logic         first,
    input  logic         last,
    output logic [127:0] state_out
);
    logic [7:0]   b [16];
    logic [7:0]   sr [16];
    logic [7:0]   sb [16];
    logic [127:0] packed_sb;
    logic [127:0] mixed;
    logic [127:0] keyed;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            b[i] = state_in[127-8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (decrypt)
                begin
                    sr[4*c+r] = b[4*((c+4-r)%4)+r];
                end
                else
                begin
                    sr[4*c+r] = b[4*((c+r)%4)+r];
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = decrypt ? aes_pkg::INV_SBOX[sr[i]] : aes_pkg::SBOX[sr[i]];
            packed_sb[127-8*i -: 8] = sb[i];
        end
        // decrypt: key added before inverse mix
        keyed = packed_sb ^ rkey;
        for (int c = 0; c < 4; c++)
        begin
            if (decrypt)
            begin
                mixed[127-32*c -: 32] = aes_pkg::inv_mix_col(keyed[127-32*c -: 32]);
            end
            else
            begin
                mixed[127-32*c -: 32] = aes_pkg::mix_col(packed_sb[127-32*c -: 32]) ^
                                         rkey[127-32*c -: 32];
            end
        end
        if (first)
        begin
            state_out = state_in ^ rkey;
        end
        else if (last)
        begin
            state_out = keyed;
        end
        else
        begin
            state_out = mixed;
        end
    end
endmodule

>>> design/aes_block_cipher_unit.sv
// ============================================================================
// AES block cipher unit
// ECB AES-128/192/256 with a shared round unit and round key store.
// ============================================================================
// Usage:
//   Input channel in_ch carries req_type, block_hi and block_lo; output
//   channel out_ch carries out_hi and out_lo, one result beat per input beat.
//   Key mode and key bytes are set on the write port (cfg_we, cfg_idx,
//   cfg_data) while the unit is idle.
//   After reset or any key write the first beat first expands the key: one
//   round key word a cycle, 44/52/60 words for 128/192/256-bit keys.
//   Each round fetches its key as four words from the store and then runs
//   through the single round unit; Nr+1 such rounds lie between acceptance
//   and result valid. in_ch.ready returns the cycle after the result beat is
//   taken.
//   One beat is in flight at a time; in_ch.ready is low from acceptance
//   until the result beat is taken.
//   The result is held in the output register while the receiver stalls.
//   Reset returns the unit to idle, clears the key registers and marks the
//   keys as not expanded.
// ============================================================================
module aes_block_cipher_unit #(
    parameter int RoundKeyWords = aes_pkg::RoundKeyWordsDefault
) (
    input  logic                         clk,
    input  logic                         rst_n,
    aes_stream_if.sink                   in_ch,
    aes_stream_if.source                 out_ch,
    input  logic                         cfg_we,
    input  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [aes_pkg::CfgDataW-1:0] cfg_data
);
    localparam int AddrW = $clog2(RoundKeyWords);

    typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_FETCH, S_ROUND, S_OUT} state_t;

    state_t        state_reg;
    logic [1:0]    mode_reg;
    logic [63:0]   key_a_reg, key_b_reg, key_c_reg, key_d_reg;
    logic          keys_ready_reg;
    logic          dec_reg;
    logic [127:0]  st_reg;
    logic [127:0]  rk_reg;
    logic [AddrW:0] widx_reg;
    logic [3:0]    round_reg;
    logic [2:0]    sub_reg;
    logic [7:0]    rcon_reg;
    logic [31:0]   prev_reg;
    logic [3:0]    kpos_reg;
    logic [31:0]   win [8];
    logic [3:0]    nk, nr;
    logic [AddrW:0] total;
    logic          we;
    logic [AddrW-1:0] waddr, raddr, raddr_calc;
    logic [31:0]   wdata, rdata, t;
    logic [127:0]  rnd_out;
    logic [3:0]    rnd_num;
    logic [5:0]    word_idx;

    always_comb
    begin
        unique case (mode_reg)
            2'd1:    nk = 4'd6;
            2'd2:    nk = 4'd8;
            default: nk = 4'd4;
        endcase
        if (4 * (int'(nk) + 7) > RoundKeyWords)
        begin
            nk = 4'd4;
        end
        nr = nk + 4'd6;
        total = (AddrW+1)'(4 * (int'(nr) + 1));
    end

    assign win = '{key_a_reg[63:32], key_a_reg[31:0], key_b_reg[63:32], key_b_reg[31:0],
                   key_c_reg[63:32], key_c_reg[31:0], key_d_reg[63:32], key_d_reg[31:0]};

    // expansion: w[i-nk] is addressed in the cycle before it is needed, as the store read is registered
    always_comb
    begin
        t = prev_reg;
        if (kpos_reg == 4'd0)
        begin
            t = aes_pkg::sub_word({prev_reg[23:0], prev_reg[31:24]}) ^ {rcon_reg, 24'h0};
        end
        else if (nk == 4'd8 && kpos_reg == 4'd4)
        begin
            t = aes_pkg::sub_word(prev_reg);
        end
    end

    always_comb
    begin
        we = 1'b0;
        waddr = widx_reg[AddrW-1:0];
        wdata = '0;
        if (state_reg == S_EXPAND)
        begin
            we = 1'b1;
            if (widx_reg < (AddrW+1)'(nk))
            begin
                wdata = win[widx_reg[2:0]];
            end
            else
            begin
                wdata = rdata ^ t;
            end
        end
    end

    assign rnd_num = dec_reg ? nr - round_reg : round_reg;
    assign word_idx = 6'({rnd_num, 2'b00}) + 6'(sub_reg[1:0]);

    always_comb
    begin
        raddr_calc = AddrW'(word_idx);
        if (state_reg == S_EXPAND || (state_reg == S_IDLE))
        begin
            raddr_calc = AddrW'(widx_reg + (AddrW+1)'(1) - (AddrW+1)'(nk));
        end
    end
    assign raddr = raddr_calc;

    aes_ram #(.Width(32), .Depth(RoundKeyWords)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    aes_round u_round (
        .state_in  (st_reg),
        .rkey      (rk_reg),
        .decrypt   (dec_reg),
        .first     (round_reg == 4'd0),
        .last      (round_reg == nr),
        .state_out (rnd_out)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data.out_hi = st_reg[127:64];
    assign out_ch.data.out_lo = st_reg[63:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= '0;
            key_a_reg <= '0;
            key_b_reg <= '0;
            key_c_reg <= '0;
            key_d_reg <= '0;
            keys_ready_reg <= 1'b0;
            dec_reg <= 1'b0;
            st_reg <= '0;
            rk_reg <= '0;
            widx_reg <= '0;
            round_reg <= '0;
            sub_reg <= '0;
            rcon_reg <= 8'h01;
            prev_reg <= '0;
            kpos_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    aes_pkg::CFG_KEY_MODE:
                    begin
                        mode_reg <= cfg_data[1:0];
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::CFG_KEY_A:
                    begin
                        key_a_reg <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::CFG_KEY_B:
                    begin
                        key_b_reg <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::CFG_KEY_C:
                    begin
                        key_c_reg <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_pkg::CFG_KEY_D:
                    begin
                        key_d_reg <= cfg_data;
                        keys_ready_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        st_reg <= {in_ch.data.block_hi, in_ch.data.block_lo};
                        dec_reg <= in_ch.data.req_type;
                        round_reg <= '0;
                        sub_reg <= '0;
                        widx_reg <= '0;
                        rcon_reg <= 8'h01;
                        kpos_reg <= '0;
                        state_reg <= keys_ready_reg ? S_FETCH : S_EXPAND;
                    end
                end
                S_EXPAND:
                begin
                    prev_reg <= wdata;
                    widx_reg <= widx_reg + (AddrW+1)'(1);
                    if (widx_reg >= (AddrW+1)'(nk))
                    begin
                        if (kpos_reg == 4'd0)
                        begin
                            rcon_reg <= aes_pkg::xtime(rcon_reg);
                        end
                        kpos_reg <= (kpos_reg + 4'd1 == nk) ? 4'd0 : kpos_reg + 4'd1;
                    end
                    if (widx_reg + (AddrW+1)'(1) == total)
                    begin
                        keys_ready_reg <= 1'b1;
                        sub_reg <= '0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    // address of word sub_reg issued this cycle, data next cycle
                    if (sub_reg != 3'd0)
                    begin
                        rk_reg <= {rk_reg[95:0], rdata};
                    end
                    if (sub_reg == 3'd4)
                    begin
                        sub_reg <= '0;
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                S_ROUND:
                begin
                    st_reg <= rnd_out;
                    if (round_reg == nr)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        round_reg <= round_reg + 4'd1;
                        state_reg <= S_FETCH;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> design/aes_checker.sv
// ============================================================================
// AES port checker
// Port-level properties of the cipher unit, bound into the cipher unit module.
// ============================================================================
module aes_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] out_hi
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready && !out_valid)
        else $error("accept not followed by busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(out_hi))
        else $error("result dropped under stall");
    a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready && !out_valid)
        else $error("not idle after result beat");
endmodule

bind aes_block_cipher_unit aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hi    (out_ch.data.out_hi)
);

>>> tb/sv/tb_aes_block_cipher_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// AES cipher result checker
// Watches the input and output channels of the AES unit, computes the expected
// cipher or inverse cipher block from the current key settings, and compares
// every result beat in order. The failure count goes to the top level.
// ============================================================================
module tb_aes_block_cipher_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    aes_stream_if.sink                   in_mon,
    aes_stream_if.sink                   out_mon,
    input  logic                         cfg_we,
    input  logic [aes_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [aes_pkg::CfgDataW-1:0] cfg_data,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);
    import aes_pkg::*;

    logic [1:0]        mode_q;
    logic [63:0]       key_q [4];
    logic [31:0]       sched [60];
    bit                sched_valid;
    logic [7:0]        isbox [256];
    out_beat_t         cipher_q [$];

    initial begin
        for (int i = 0; i < 256; i++)
        begin
            isbox[SBOX[i]] = i[7:0];
        end
    end

    function automatic logic [7:0] dbl(input logic [7:0] p);
        return {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= a;
            a = dbl(a);
        end
        return acc;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic int key_len_words();
        return (mode_q == 2'd1) ? 6 : (mode_q == 2'd2) ? 8 : 4;
    endfunction

    task automatic build_schedule();
        logic [31:0] kw [8];
        logic [31:0] t;
        logic [7:0]  rc;
        int          nk;
        int          total;
        nk = key_len_words();
        total = 4 * (nk + 7);
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            kw[2*i]   = key_q[i][63:32];
            kw[2*i+1] = key_q[i][31:0];
        end
        for (int i = 0; i < nk; i++)
            sched[i] = kw[i];
        for (int i = nk; i < total; i++)
        begin
            t = sched[i-1];
            if (i % nk == 0)
            begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sbox_word(t);
            sched[i] = sched[i-nk] ^ t;
        end
        sched_valid = 1'b1;
    endtask

    function automatic logic [127:0] add_key(input logic [127:0] s, input int r);
        return s ^ {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
    endfunction

    function automatic logic [127:0] sub_all(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
            o[127-8*i -: 8] = inv ? isbox[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        return o;
    endfunction

    function automatic logic [127:0] shift_all(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                o[127-8*(4*c+r) -: 8] = s[127-8*(4*src+r) -: 8];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
        logic [7:0]   m [4];
        logic [7:0]   acc;
        logic [127:0] o;
        if (inv)
            m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            m = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gf_mul(s[127-8*(4*c+k) -: 8], m[(k + 4 - r) % 4]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        return o;
    endfunction

    function automatic out_beat_t aes_transform(input in_beat_t b);
        logic [127:0] s;
        int nr;
        out_beat_t res;
        nr = key_len_words() + 6;
        s = {b.block_hi, b.block_lo};
        if (b.req_type == REQ_ENCRYPT)
        begin
            s = add_key(s, 0);
            for (int r = 1; r < nr; r++)
                s = add_key(mix_all(shift_all(sub_all(s, 0), 0), 0), r);
            s = add_key(shift_all(sub_all(s, 0), 0), nr);
        end
        else
        begin
            s = add_key(s, nr);
            for (int r = nr - 1; r >= 1; r--)
                s = mix_all(add_key(sub_all(shift_all(s, 1), 1), r), 1);
            s = add_key(sub_all(shift_all(s, 1), 1), 0);
        end
        res.out_hi = s[127:64];
        res.out_lo = s[63:0];
        return res;
    endfunction

    assign pending = cipher_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            mode_q = 2'd0;
            key_q = '{default: 64'h0};
            sched_valid = 1'b0;
            cipher_q.delete();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_KEY_MODE: begin mode_q = cfg_data[1:0]; sched_valid = 1'b0; end
                    CFG_KEY_A:    begin key_q[0] = cfg_data; sched_valid = 1'b0; end
                    CFG_KEY_B:    begin key_q[1] = cfg_data; sched_valid = 1'b0; end
                    CFG_KEY_C:    begin key_q[2] = cfg_data; sched_valid = 1'b0; end
                    CFG_KEY_D:    begin key_q[3] = cfg_data; sched_valid = 1'b0; end
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (!sched_valid)
                    build_schedule();
                cipher_q.push_back(aes_transform(in_mon.data));
            end
            if (out_mon.valid && out_mon.ready)
            begin
                results_seen <= results_seen + 1;
                if (cipher_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result beat %h", out_mon.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = cipher_q.pop_front();
                    if (want.out_hi !== out_mon.data.out_hi
                        || want.out_lo !== out_mon.data.out_lo)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: beat %0d exp %h_%h got %h_%h", results_seen,
                                     want.out_hi, want.out_lo,
                                     out_mon.data.out_hi, out_mon.data.out_lo);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/tb_aes_block_cipher_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// AES block cipher unit testbench
// Drives directed and random encrypt/decrypt beats through the AES unit under
// all key lengths, with random input bursts and output stalls, and reports
// the verdict from the checker's failure count and pending beats.
// ============================================================================
module tb_aes_block_cipher_unit;
    import aes_pkg::*;

    localparam int CycleLimit = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = CFG_KEY_MODE;
    logic [CfgDataW-1:0] cfg_data = '0;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   cycles = 0;
    int   blocks_sent = 0;
    bit   long_hold = 1'b0;
    bit   stall_on = 1'b1;

    aes_stream_if #(.payload_t(in_beat_t))  in_ch ();
    aes_stream_if #(.payload_t(out_beat_t)) out_ch ();

    aes_block_cipher_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    tb_aes_block_cipher_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n || long_hold)
            out_ch.ready <= 1'b0;
        else if (!stall_on)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("Timeout at cycle %0d", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic load_key(input logic [1:0] mode, input logic [63:0] a,
                            input logic [63:0] b, input logic [63:0] c,
                            input logic [63:0] d);
        write_reg(CFG_KEY_MODE, {62'h0, mode});
        write_reg(CFG_KEY_A, a);
        write_reg(CFG_KEY_B, b);
        write_reg(CFG_KEY_C, c);
        write_reg(CFG_KEY_D, d);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_block(input logic rt, input logic [63:0] hi, input logic [63:0] lo,
                              input bit keep_valid);
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{block_hi: hi, block_lo: lo, req_type: rt};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        blocks_sent++;
        if (!keep_valid)
            in_ch.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_phase(input int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(0, 20)) @(posedge clk);
            end
            burst--;
            send_block(1'($urandom_range(0, 1)), rnd64(), rnd64(),
                       burst != 0 && i != n - 1);
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: all zero, 128 bit
        send_block(REQ_ENCRYPT, 64'h0, 64'h0, 0);
        send_block(REQ_DECRYPT, 64'h0, 64'h0, 0);
        drain();

        load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'hdeadbeefdeadbeef, 64'hffffffffffffffff);
        send_block(REQ_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block(REQ_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 0);
        send_block(REQ_ENCRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 0);
        send_block(REQ_DECRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff, 0);
        drain();

        load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h0);
        send_block(REQ_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block(REQ_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 0);
        drain();

        load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(REQ_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 0);
        send_block(REQ_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 0);
        drain();

        // mode three acts as 128 bit; all ones key
        load_key(2'd3, '1, '1, '1, '1);
        send_block(REQ_ENCRYPT, 64'h0, 64'h0, 0);
        send_block(REQ_DECRYPT, 64'h0, 64'h0, 0);
        drain();

        // out-of-range index: must not disturb the schedule
        write_reg(3'd7, rnd64());
        write_reg(3'd5, rnd64());
        send_block(REQ_ENCRYPT, 64'h8000000000000001, 64'h0123456789abcdef, 0);
        drain();

        // long receiver hold while the sender keeps offering
        long_hold = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            random_phase(6);
        join
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            load_key(2'(ph % 4), rnd64(), rnd64(), rnd64(), rnd64());
            stall_on = (ph != 3);
            random_phase(70);
            drain();
        end
        stall_on = 1'b1;
        load_key(2'd2, 64'h0, '1, 64'h0, '1);
        random_phase(20);
        drain();

        $display("Sent %0d blocks, checked %0d results over all key lengths, both directions",
                 blocks_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> filelist.f
design/aes_pkg.sv
design/aes_stream_if.sv
design/aes_ram.sv
design/aes_round.sv
design/aes_block_cipher_unit.sv
design/aes_checker.sv
tb/sv/tb_aes_block_cipher_checker.sv
tb/sv/tb_aes_block_cipher_unit.sv
